FILE: sv/key_press_repeat_scanner_core_macros.svh
// ----------------------------------------------------------------------------
// Key press repeat scanner: assertion macros
// Shared property forms for the checker; the clock and reset come from the
// scope of the module that uses them.
// ----------------------------------------------------------------------------
`ifndef KEY_PRESS_REPEAT_SCANNER_CORE_MACROS_SVH
`define KEY_PRESS_REPEAT_SCANNER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KPRS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KPRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/kprs_pkg.sv
// ----------------------------------------------------------------------------
// Key press repeat scanner package
// Types, register indexes, event codes and reset values shared by the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kprs_pkg;

	localparam int NUM_KEYS = 3;
	localparam int CNT_W    = 8;
	localparam int CFG_IDX_W = 2;

	typedef logic [NUM_KEYS-1:0] keys_t;
	typedef logic [CNT_W-1:0]    cnt_t;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_SHORT  = 2'd1,
		KIND_REPEAT = 2'd2,
		KIND_LONG   = 2'd3
	} event_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HOLD_TICKS    = 2'd0,
		CFG_REPEAT_RELOAD = 2'd1,
		CFG_LONG_REPEATS  = 2'd2
	} cfg_index_t;

	localparam cnt_t HOLD_TICKS_RST    = 8'd50;
	localparam cnt_t REPEAT_RELOAD_RST = 8'd40;
	localparam cnt_t LONG_REPEATS_RST  = 8'd30;

	typedef struct packed {
		cnt_t hold_ticks;
		cnt_t repeat_reload;
		cnt_t long_press_repeats;
	} cfg_t;

	typedef struct packed {
		keys_t last_keys;
		cnt_t  hold_count;
		cnt_t  repeat_count;
		keys_t latched_keys;
		logic  pressed;
		logic  repeating;
	} scan_state_t;

endpackage

FILE: sv/kprs_step.sv
// ----------------------------------------------------------------------------
// Key press repeat scanner: tick update
// Next-state and event logic for one scan tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kprs_step (
	input  kprs_pkg::keys_t       keys,
	input  kprs_pkg::scan_state_t cur,
	input  kprs_pkg::cfg_t        cfg,
	output kprs_pkg::scan_state_t nxt,
	output kprs_pkg::event_kind_t kind,
	output kprs_pkg::keys_t       ev_keys
);
	import kprs_pkg::*;

	cnt_t hold_inc;

	assign hold_inc = cur.hold_count + cnt_t'(1);

	always_comb begin
		nxt     = cur;
		kind    = KIND_NONE;
		ev_keys = '0;
		if (keys != '0) begin
			if (cur.last_keys == keys) begin
				nxt.hold_count = hold_inc;
				if (hold_inc < cfg.hold_ticks) begin
					if (!cur.repeating) begin
						nxt.pressed      = 1'b1;
						nxt.latched_keys = keys;
					end
				end else begin
					// The repeat count is compared before it advances, so the
					// first repeat is number zero.
					nxt.repeating    = 1'b1;
					kind             = (cur.repeat_count == cfg.long_press_repeats) ?
						KIND_LONG : KIND_REPEAT;
					ev_keys          = keys;
					nxt.repeat_count = cur.repeat_count + cnt_t'(1);
					nxt.hold_count   = cfg.repeat_reload;
				end
			end
			nxt.last_keys = keys;
		end else begin
			if (cur.pressed && !cur.repeating) begin
				kind    = KIND_SHORT;
				ev_keys = cur.latched_keys;
			end
			nxt.pressed      = 1'b0;
			nxt.repeating    = 1'b0;
			nxt.hold_count   = '0;
			nxt.repeat_count = '0;
			nxt.last_keys    = '0;
		end
	end

endmodule

FILE: sv/key_press_repeat_scanner_core.sv
// ----------------------------------------------------------------------------
// Key press repeat scanner core
// Debounced key scanning with short press, autorepeat and long press events.
//
//   channel   | signals                     | meaning
//   s_axis    | tvalid tready tdata         | one scan tick of pressed keys
//   m_axis    | tvalid tready tdata tuser   | one event result per tick
//   cfg       | valid ready index data      | register writes, always ready
//
// From acceptance, each tick passes an input register, then the tick update
// into the result register. One tick is accepted per cycle while results
// drain. The scan state advances only when the input register moves into
// the result register, so a stall on m_axis holds both stages. Reset clears
// the scan state and loads the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_press_repeat_scanner_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [2:0] keys_down, [7:3] zero
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [2:0] event_keys, [7:3] zero
	output logic [1:0] m_axis_tuser,  // [1:0] event_kind
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import kprs_pkg::*;

	logic        valid_s1;
	keys_t       keys_s1;
	logic        out_valid_q;
	event_kind_t kind_q;
	keys_t       ev_keys_q;
	scan_state_t state_q;
	cfg_t        cfg_q;
	scan_state_t state_nxt;
	event_kind_t kind_nxt;
	keys_t       ev_keys_nxt;
	logic        advance;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_ticks         <= HOLD_TICKS_RST;
			cfg_q.repeat_reload      <= REPEAT_RELOAD_RST;
			cfg_q.long_press_repeats <= LONG_REPEATS_RST;
		end else if (cfg_valid) begin
			case (cfg_index_t'(cfg_index))
				CFG_HOLD_TICKS:    cfg_q.hold_ticks         <= cfg_data;
				CFG_REPEAT_RELOAD: cfg_q.repeat_reload      <= cfg_data;
				CFG_LONG_REPEATS:  cfg_q.long_press_repeats <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			keys_s1 <= s_axis_tdata[NUM_KEYS-1:0];
		end
	end

	kprs_step u_step (
		.keys    (keys_s1),
		.cur     (state_q),
		.cfg     (cfg_q),
		.nxt     (state_nxt),
		.kind    (kind_nxt),
		.ev_keys (ev_keys_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_q    <= kind_nxt;
			ev_keys_q <= ev_keys_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(8-NUM_KEYS){1'b0}}, ev_keys_q};
	assign m_axis_tuser  = kind_q;

endmodule

FILE: sv/kprs_checker.sv
// ----------------------------------------------------------------------------
// Key press repeat scanner checker
// Port-level properties of the core, attached to it by a bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "key_press_repeat_scanner_core_macros.svh"

module kprs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic [1:0] m_axis_tuser
);
	import kprs_pkg::*;

	// A tick with no event reports no keys.
	`KPRS_ASSERT_IMPL(a_none_no_keys, m_axis_tvalid && (m_axis_tuser == KIND_NONE), m_axis_tdata == 8'd0, "event without kind carries keys")

	// Every real event names at least one key and keeps the padding clear.
	`KPRS_ASSERT_IMPL(a_event_has_keys, m_axis_tvalid && (m_axis_tuser != KIND_NONE), (m_axis_tdata[2:0] != 3'd0) && (m_axis_tdata[7:3] == 5'd0), "event with empty key set")

	// A stalled result transaction holds its payload.
	`KPRS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

endmodule

bind key_press_repeat_scanner_core kprs_checker u_kprs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Key press repeat scanner testbench
// Streams scan ticks into the core and checks every event transaction it
// returns against an in-bench scan model. Runs through several register
// settings, from the reset defaults to both extremes, with random idle bursts
// on both sides of the stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import kprs_pkg::*;

	localparam int         QUIET_LIMIT    = 1000;
	localparam int         MAX_REPORTS    = 10;
	localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;

	typedef struct packed {
		event_kind_t kind;
		keys_t       keys;
	} scan_event_t;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = '0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic       cfg_valid     = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index     = '0;
	logic [7:0] cfg_data      = '0;

	keys_t       pending_keys[$];
	scan_event_t expected_events[$];
	scan_state_t scan_st  = '0;
	cfg_t        scan_cfg = '{HOLD_TICKS_RST, REPEAT_RELOAD_RST, LONG_REPEATS_RST};

	bit idle_on = 1'b1;
	int gap_left = 0;
	int stall_left = 0;
	int mismatch_count = 0;
	int quiet_cycles = 0;
	int phase_items = 0;

	key_press_repeat_scanner_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #4 clk = ~clk;

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// One scan tick of the key scanner: debounce, short press, repeat and long press.
	function automatic scan_event_t scan_tick(input keys_t keys);
		scan_event_t ev;
		ev.kind = KIND_NONE;
		ev.keys = '0;
		if (keys != '0) begin
			if (scan_st.last_keys == keys) begin
				scan_st.hold_count = scan_st.hold_count + 8'd1;
				if (scan_st.hold_count < scan_cfg.hold_ticks) begin
					if (!scan_st.repeating) begin
						scan_st.pressed      = 1'b1;
						scan_st.latched_keys = keys;
					end
				end else begin
					scan_st.repeating = 1'b1;
					ev.kind = (scan_st.repeat_count == scan_cfg.long_press_repeats) ?
						KIND_LONG : KIND_REPEAT;
					ev.keys = keys;
					scan_st.repeat_count = scan_st.repeat_count + 8'd1;
					scan_st.hold_count   = scan_cfg.repeat_reload;
				end
			end
			scan_st.last_keys = keys;
		end else begin
			if (scan_st.pressed && !scan_st.repeating) begin
				ev.kind = KIND_SHORT;
				ev.keys = scan_st.latched_keys;
			end
			scan_st.pressed      = 1'b0;
			scan_st.repeating    = 1'b0;
			scan_st.hold_count   = '0;
			scan_st.repeat_count = '0;
			scan_st.last_keys    = '0;
		end
		return ev;
	endfunction

	// Tick driver: predicts each accepted tick, then loads the next one or idles.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_events.push_back(scan_tick(keys_t'(s_axis_tdata[NUM_KEYS-1:0])));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pending_keys.size() == 0) begin
					s_axis_tvalid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 19) == 0) begin
					gap_left <= $urandom_range(0, 17);
					s_axis_tvalid <= 1'b0;
				end else begin
					s_axis_tdata <= 8'(pending_keys.pop_front());
					s_axis_tvalid <= 1'b1;
				end
			end
		end
	end

	// Event monitor with random back-pressure.
	always @(posedge clk) begin
		scan_event_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_events.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("event kind %0d keys %0d arrived with nothing expected",
							m_axis_tuser, m_axis_tdata[NUM_KEYS-1:0]);
				end else begin
					want = expected_events.pop_front();
					if (m_axis_tuser !== want.kind ||
							m_axis_tdata[NUM_KEYS-1:0] !== want.keys) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$display("event mismatch: kind exp %0d got %0d, keys exp %0d got %0d",
								want.kind, m_axis_tuser, want.keys,
								m_axis_tdata[NUM_KEYS-1:0]);
					end
				end
			end
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				m_axis_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 15) == 0) begin
				stall_left <= $urandom_range(0, 17);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic push_keys(input keys_t keys, input int count);
		repeat (count) begin
			pending_keys.push_back(keys);
			phase_items++;
		end
	endtask

	// One press sequence: taps, holds into repeats, noise or a set change, then release.
	task automatic press_burst();
		keys_t k;
		keys_t k2;
		int span;
		int len;
		int mode;
		k  = keys_t'($urandom_range(1, 7));
		k2 = keys_t'($urandom_range(1, 7));
		span = int'(scan_cfg.hold_ticks) - int'(scan_cfg.repeat_reload);
		if (span < 1)
			span = 1;
		mode = $urandom_range(0, 9);
		if (mode <= 3) begin
			push_keys(k, $urandom_range(1, 3));
		end else if (mode <= 7) begin
			len = int'(scan_cfg.hold_ticks) + span * $urandom_range(0, 4) + $urandom_range(0, 3);
			if (len > 150)
				len = $urandom_range(1, 150);
			push_keys(k, len);
		end else if (mode == 8) begin
			repeat ($urandom_range(1, 6))
				push_keys(keys_t'($urandom_range(0, 7)), 1);
		end else begin
			push_keys(k, $urandom_range(1, 6));
			push_keys(k2, $urandom_range(1, int'(scan_cfg.hold_ticks) + 2));
		end
		push_keys('0, $urandom_range(1, 3));
	endtask

	task automatic random_part(input int budget);
		phase_items = 0;
		while (phase_items < budget)
			press_burst();
	endtask

	// Waits until every tick has gone out and every event has come back.
	task automatic drain();
		@(negedge clk);
		while (pending_keys.size() != 0 || s_axis_tvalid || expected_events.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_cfg(input logic [1:0] idx, input cnt_t value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		case (idx)
			CFG_HOLD_TICKS:    scan_cfg.hold_ticks = value;
			CFG_REPEAT_RELOAD: scan_cfg.repeat_reload = value;
			CFG_LONG_REPEATS:  scan_cfg.long_press_repeats = value;
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic set_cfg(input cnt_t hold, input cnt_t reload, input cnt_t long_rep);
		write_cfg(CFG_HOLD_TICKS, hold);
		write_cfg(CFG_REPEAT_RELOAD, reload);
		write_cfg(CFG_LONG_REPEATS, long_rep);
	endtask

	initial begin
		keys_t taps[];
		taps = '{3'd7, 3'd0, 3'd1, 3'd1, 3'd0, 3'd2, 3'd2, 3'd2, 3'd0,
			3'd4, 3'd4, 3'd6, 3'd6, 3'd0, 3'd7, 3'd7, 3'd0,
			3'd3, 3'd5, 3'd3, 3'd0, 3'd5, 3'd5, 3'd3, 3'd0};
		wait (arst_n === 1'b1);
		@(posedge clk);

		// Reset defaults: unconfirmed taps, short presses, a set change while held,
		// then a hold through the first two repeats.
		foreach (taps[i])
			push_keys(taps[i], 1);
		push_keys(3'd1, 62);
		push_keys('0, 1);
		random_part(100);
		drain();

		// Threshold of one: the first confirmed tick already repeats as a long press.
		set_cfg(8'd1, 8'd0, 8'd0);
		random_part(120);
		drain();

		// Highest threshold and a reload just below it.
		set_cfg(8'd255, 8'd254, 8'd255);
		push_keys(3'd3, 258);
		push_keys('0, 1);
		random_part(40);
		drain();

		// Zero threshold with a wrapping reload; the repeat counter wraps and the
		// long press comes back after 256 repeats.
		set_cfg(8'd0, 8'd255, 8'd0);
		push_keys(3'd5, 262);
		push_keys('0, 1);
		random_part(40);
		drain();

		set_cfg(8'd4, 8'd2, 8'd3);
		random_part(200);
		drain();

		// A write to an unused index must leave the registers alone.
		write_cfg(CFG_UNUSED_IDX, 8'hA5);
		set_cfg(cnt_t'($urandom_range(1, 12)), cnt_t'($urandom_range(0, 12)),
			cnt_t'($urandom_range(0, 6)));
		idle_on = 1'b0;
		random_part(150);
		drain();

		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_events.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
